/* rtl/core/aevd_pkg.sv */
// ----------------------------------------------------------------------------
// aevd_pkg
// Shared types and constants of the adaptive energy voice detector.
// ----------------------------------------------------------------------------
package aevd_pkg;

  localparam int unsigned MaxFrameSamples = 512;
  localparam int unsigned CntW            = $clog2(MaxFrameSamples + 1);
  localparam int unsigned SampleW         = 16;
  localparam int unsigned SumW            = 32;
  localparam int unsigned StepW           = $clog2(SumW);
  localparam int unsigned EnergyW         = 31;
  localparam int unsigned EnergyShift     = 8;
  localparam int unsigned QuotW           = EnergyW - EnergyShift;
  localparam int unsigned LeakShift       = 10;
  localparam int unsigned FloorMin        = 200;
  localparam int unsigned MarginW         = 8;
  localparam int unsigned ThrW            = EnergyW + MarginW;
  localparam int unsigned HangW           = 16;
  localparam int unsigned HangLeftW       = 18;
  localparam int unsigned TypeW           = 4;
  localparam int unsigned AddrW           = 4;
  localparam int unsigned DataW           = 32;

  localparam logic [EnergyW-1:0] MinEnergyRst = EnergyW'(10000);
  localparam logic [MarginW-1:0] MarginRst    = MarginW'(4);

  typedef enum logic [1:0] {
    REG_RATE_SET   = 2'd0,
    REG_MIN_ENERGY = 2'd1,
    REG_MARGIN     = 2'd2,
    REG_HANGOVER   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    SPEECH_UNKNOWN = 2'd0,
    SPEECH_SILENT  = 2'd1,
    SPEECH_ACTIVE  = 2'd2,
    SPEECH_ECHO    = 2'd3
  } speech_state_e;

  typedef struct packed {
    logic               rate_set;
    logic [EnergyW-1:0] min_energy;
    logic [MarginW-1:0] margin;
    logic [HangW-1:0]   hangover;
  } cfg_t;

  typedef struct packed {
    logic acc;        // sample transaction: accumulate
    logic start;      // last sample accepted: arm the divider
    logic div_step;   // one quotient bit
    logic floor_upd;  // noise floor update
    logic thr_load;   // floor times margin
    logic out_load;   // decide and write the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic detect;     // rate set and not energy-only
  } dp_status_t;

endpackage

/* rtl/core/adaptive_energy_voice_detector_core.sv */
// ----------------------------------------------------------------------------
// adaptive_energy_voice_detector_core
// Frame energy voice activity detector with adaptive noise floor and
// hangover; APB register port.
// ----------------------------------------------------------------------------
//  channel | signals                                         | transfer
//  --------+-------------------------------------------------+----------------
//  in      | in_valid_i/in_ready_o, sample_i, last_of_frame_i | one audio sample
//          | energy_only_i, caller_type_i, restart_i          |
//  out     | out_valid_o/out_ready_i, speech_state_o,         | one per frame
//          | frame_energy_o, caller_type_echo_o               |
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata/pready   | register access
//
// A sample that does not end a frame leaves in_ready_o high. The last sample of a
// frame drops in_ready_o until the result is written, while the block runs the
// 32-step bit-serial divider, then the floor update and multiply steps (detect
// only; skipped for energy only or rate not set), then the decide step.
// A stalled result holds the block in its decide step.
// Reset clears control and adaptation state, not the payload registers; no clearing pass.
// ----------------------------------------------------------------------------
module adaptive_energy_voice_detector_core import aevd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [AddrW-1:0]          paddr,
  input  logic [DataW-1:0]          pwdata,
  output logic [DataW-1:0]          prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      last_of_frame_i,
  input  logic                      energy_only_i,
  input  logic [TypeW-1:0]          caller_type_i,
  input  logic                      restart_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                speech_state_o,
  output logic [EnergyW-1:0]        frame_energy_o,
  output logic [TypeW-1:0]          caller_type_echo_o
);

  cfg_t       cfg_q;
  reg_idx_e   reg_idx;
  logic       cfg_we;
  logic       cfg_clr;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_we  = psel && penable && pwrite && pready;
  // writing the rate register restarts adaptation
  assign cfg_clr = cfg_we && (reg_idx == REG_RATE_SET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_set   <= 1'b0;
      cfg_q.min_energy <= MinEnergyRst;
      cfg_q.margin     <= MarginRst;
      cfg_q.hangover   <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_RATE_SET:   cfg_q.rate_set   <= pwdata[0];
        REG_MIN_ENERGY: cfg_q.min_energy <= pwdata[EnergyW-1:0];
        REG_MARGIN:     cfg_q.margin     <= pwdata[MarginW-1:0];
        REG_HANGOVER:   cfg_q.hangover   <= pwdata[HangW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RATE_SET:   prdata = DataW'(cfg_q.rate_set);
      REG_MIN_ENERGY: prdata = DataW'(cfg_q.min_energy);
      REG_MARGIN:     prdata = DataW'(cfg_q.margin);
      REG_HANGOVER:   prdata = DataW'(cfg_q.hangover);
      default:        prdata = '0;
    endcase
  end

  aevd_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .last_of_frame_i (last_of_frame_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cmd_o           (cmd),
    .status_i        (status)
  );

  aevd_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_i              (cfg_q),
    .cfg_clr_i          (cfg_clr),
    .sample_i           (sample_i),
    .energy_only_i      (energy_only_i),
    .caller_type_i      (caller_type_i),
    .restart_i          (restart_i),
    .speech_state_o     (speech_state_o),
    .frame_energy_o     (frame_energy_o),
    .caller_type_echo_o (caller_type_echo_o)
  );

endmodule

/* rtl/core/aevd_dp.sv */
// ----------------------------------------------------------------------------
// aevd_dp
// Datapath: energy accumulator, bit-serial divider, noise floor, threshold,
// hangover counter and result register.
// ----------------------------------------------------------------------------
module aevd_dp import aevd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  output dp_status_t                status_o,
  input  cfg_t                      cfg_i,
  input  logic                      cfg_clr_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      energy_only_i,
  input  logic [TypeW-1:0]          caller_type_i,
  input  logic                      restart_i,
  output logic [1:0]                speech_state_o,
  output logic [EnergyW-1:0]        frame_energy_o,
  output logic [TypeW-1:0]          caller_type_echo_o
);

  logic [SumW-1:0]      sum_q, sum_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      rem_q, rem_d;
  logic [EnergyW-1:0]   floor_q, floor_d;
  logic                 floor_valid_q, floor_valid_d;
  logic [HangLeftW-1:0] hang_q, hang_d;
  logic                 eonly_q;
  logic [TypeW-1:0]     ctype_q;
  logic [ThrW-1:0]      thr_q;
  speech_state_e        state_q;
  logic [EnergyW-1:0]   energy_out_q;
  logic [TypeW-1:0]     echo_q;

  logic [SampleW-1:0]   mag;
  logic [SumW-1:0]      sq;
  logic [SumW-1:0]      acc_sum;
  logic [CntW:0]        rem_sh;
  logic [CntW:0]        rem_sub;
  logic                 q_bit;
  logic [EnergyW-1:0]   energy;
  logic [SumW-1:0]      leak;
  logic [EnergyW-1:0]   floor_new;
  logic [ThrW-1:0]      prod;
  logic [ThrW-1:0]      thr_eff;
  logic                 active;
  logic                 hang_pos;
  logic                 clr_adapt;

  // |x| of a 16-bit two's complement value; -32768 maps to 32768
  assign mag     = sample_i[SampleW-1] ? ($unsigned(~sample_i) + 1'b1) : $unsigned(sample_i);
  assign sq      = mag * mag;
  assign acc_sum = sum_q + SumW'(sq >> EnergyShift);

  // restoring division of the sum by the count, quotient shifts into sum_q
  assign rem_sh  = {rem_q, sum_q[SumW-1]};
  assign q_bit   = rem_sh >= {1'b0, count_q};
  assign rem_sub = rem_sh - {1'b0, count_q};

  assign energy  = (count_q == '0) ? '0 : {sum_q[QuotW-1:0], {EnergyShift{1'b0}}};

  assign leak    = SumW'(floor_q) + SumW'(floor_q >> LeakShift) + SumW'(1);

  always_comb begin
    if (!floor_valid_q || (energy < floor_q)) begin
      floor_new = energy;
    end else if (leak[SumW-1]) begin
      floor_new = '1;
    end else begin
      floor_new = leak[EnergyW-1:0];
    end
    if (floor_new < EnergyW'(FloorMin)) begin
      floor_new = EnergyW'(FloorMin);
    end
  end

  assign prod     = floor_q * cfg_i.margin;
  assign thr_eff  = (thr_q < ThrW'(cfg_i.min_energy)) ? ThrW'(cfg_i.min_energy) : thr_q;
  assign active   = ThrW'(energy) > thr_eff;
  assign hang_pos = !hang_q[HangLeftW-1] && (hang_q != '0);

  assign clr_adapt = cfg_clr_i || (cmd_i.acc && restart_i);

  assign status_o.detect = cfg_i.rate_set && !eonly_q;

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    rem_d   = rem_q;
    if (cmd_i.acc && (count_q < CntW'(MaxFrameSamples))) begin
      sum_d   = acc_sum;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.start) begin
      rem_d = '0;
    end
    if (cmd_i.div_step) begin
      rem_d = q_bit ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
      sum_d = {sum_q[SumW-2:0], q_bit};
    end
    if (cmd_i.out_load) begin
      sum_d   = '0;
      count_d = '0;
    end
  end

  always_comb begin
    floor_d       = floor_q;
    floor_valid_d = floor_valid_q;
    hang_d        = hang_q;
    if (clr_adapt) begin
      floor_d       = '0;
      floor_valid_d = 1'b0;
      hang_d        = '0;
    end else if (cmd_i.floor_upd) begin
      floor_d       = floor_new;
      floor_valid_d = 1'b1;
    end else if (cmd_i.out_load && status_o.detect) begin
      if (active) begin
        hang_d = HangLeftW'(cfg_i.hangover);
      end else if (hang_pos) begin
        hang_d = hang_q - HangLeftW'(count_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q         <= '0;
      count_q       <= '0;
      rem_q         <= '0;
      floor_q       <= '0;
      floor_valid_q <= 1'b0;
      hang_q        <= '0;
    end else begin
      sum_q         <= sum_d;
      count_q       <= count_d;
      rem_q         <= rem_d;
      floor_q       <= floor_d;
      floor_valid_q <= floor_valid_d;
      hang_q        <= hang_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      eonly_q <= energy_only_i;
      ctype_q <= caller_type_i;
    end
    if (cmd_i.thr_load) begin
      thr_q <= prod;
    end
    if (cmd_i.out_load) begin
      if (!cfg_i.rate_set) begin
        state_q      <= SPEECH_UNKNOWN;
        energy_out_q <= '0;
        echo_q       <= '0;
      end else if (eonly_q) begin
        state_q      <= SPEECH_ECHO;
        energy_out_q <= energy;
        echo_q       <= ctype_q;
      end else begin
        state_q      <= (active || hang_pos) ? SPEECH_ACTIVE : SPEECH_SILENT;
        energy_out_q <= energy;
        echo_q       <= '0;
      end
    end
  end

  assign speech_state_o     = state_q;
  assign frame_energy_o     = energy_out_q;
  assign caller_type_echo_o = echo_q;

  a_floor_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    floor_valid_q |-> (floor_q >= EnergyW'(FloorMin)))
    else $error("noise floor below minimum");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxFrameSamples))
    else $error("sample count overflow");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && (count_q != '0)) |-> (rem_q < count_q))
    else $error("divider remainder out of range");

endmodule

/* rtl/core/aevd_ctrl.sv */
// ----------------------------------------------------------------------------
// aevd_ctrl
// Controller: input/output handshakes and frame-end sequencing
// (divide, floor update and threshold when detecting, decide).
// ----------------------------------------------------------------------------
module aevd_ctrl import aevd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       last_of_frame_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ctrl_cmd_t  cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FLOOR,
    ST_MUL,
    ST_OUT
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;
  logic             in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.acc       = in_fire;
    cmd_o.start     = in_fire && last_of_frame_i;
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.floor_upd = (state_q == ST_FLOOR);
    cmd_o.thr_load  = (state_q == ST_MUL);
    cmd_o.out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.start) begin
            state_q <= ST_DIV;
            step_q  <= '0;
          end
        end
        ST_DIV: begin
          step_q <= step_q + 1'b1;  // wraps to zero on the last step
          if (step_q == StepW'(SumW - 1)) begin
            state_q <= status_i.detect ? ST_FLOOR : ST_OUT;
          end
        end
        ST_FLOOR: state_q <= ST_MUL;
        ST_MUL:   state_q <= ST_OUT;
        ST_OUT: begin
          if (cmd_o.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DIV) |-> (step_q == '0))
    else $error("divider step count not cleared");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result written but not presented");

  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> (state_q == ST_OUT))
    else $error("decision overwrote a pending result");

endmodule
